// ===== src/dccb_pkg.sv =====
`timescale 1ns / 1ps
package dccb_pkg;

    localparam int MAX_COLORS_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;

    // widest values the parameters may take, used for the queue entry
    localparam int ADDR_W     = 6;
    localparam int CNT_W      = 32;
    localparam int FIFO_DEPTH = 4;

    localparam int RGB_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int CIDX_W  = 4;
    localparam int AMT_W   = 16;
    localparam int CREG_W  = 2;
    localparam int COLS_W  = 5;
    localparam int SCALE_W = 9;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_COUNT = 1'b1
    } t_op;

    localparam logic [CREG_W-1:0] REG_COLORS = 2'd0;
    localparam logic [CREG_W-1:0] REG_BLACK  = 2'd1;
    localparam logic [CREG_W-1:0] REG_SCALE  = 2'd2;

    typedef struct packed {
        t_op               op;
        logic              hit;   // index inside the palette
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [RGB_W-1:0]  color;
        logic [CNT_W-1:0]  amt;   // already saturated to the count width
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic [CHAN_W-1:0] chan_of(input logic [RGB_W-1:0] rgb,
                                                  input logic [1:0] ch);
        logic [CHAN_W-1:0] c;
        case (ch)
            2'd0:    c = rgb[23:16];
            2'd1:    c = rgb[15:8];
            default: c = rgb[7:0];
        endcase
        return c;
    endfunction

endpackage

// ===== src/dccb_ifs.sv =====
`timescale 1ns / 1ps
interface dccb_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [3:0]  color_index;
    logic [23:0] color_value;
    logic [15:0] amount;
    logic        last_of_position;

    modport source (output valid, op, color_index, color_value, amount, last_of_position,
                    input ready);
    modport sink (input valid, op, color_index, color_value, amount, last_of_position,
                  output ready);
endinterface

interface dccb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

interface dccb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/dccb_front.sv =====
`timescale 1ns / 1ps
module dccb_front #(
    parameter int MAX_COLORS = dccb_pkg::MAX_COLORS_DEF,
    parameter int COUNT_BITS = dccb_pkg::COUNT_BITS_DEF
) (
    dccb_in_if.sink              i_in,
    input  dccb_pkg::t_fifo_stat i_stat,
    output logic                 o_push,
    output dccb_pkg::t_cmd       o_cmd
);

    localparam logic [31:0] CMAX = (COUNT_BITS >= 32) ? 32'hFFFF_FFFF
                                 : ((32'd1 << COUNT_BITS) - 32'd1);

    logic [31:0] w_amt;

    assign w_amt     = 32'(i_in.amount);
    assign i_in.ready = !i_stat.full;
    assign o_push    = i_in.valid && !i_stat.full;

    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = dccb_pkg::t_op'(i_in.op);
        o_cmd.hit   = (32'(i_in.color_index) < MAX_COLORS);
        o_cmd.last  = i_in.last_of_position && (i_in.op == dccb_pkg::OP_COUNT);
        o_cmd.addr  = dccb_pkg::ADDR_W'(i_in.color_index);
        o_cmd.color = i_in.color_value;
        // counts beyond the storage width saturate
        o_cmd.amt   = (w_amt > CMAX) ? CMAX : w_amt;
    end

endmodule

// ===== src/dccb_fifo.sv =====
`timescale 1ns / 1ps
module dccb_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  dccb_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output dccb_pkg::t_cmd       o_cmd,
    output dccb_pkg::t_fifo_stat o_stat
);

    localparam int DEPTH = dccb_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    dccb_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [PW:0]    r_cnt;

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

// ===== src/dccb_back.sv =====
`timescale 1ns / 1ps
module dccb_back #(
    parameter int MAX_COLORS = dccb_pkg::MAX_COLORS_DEF,
    parameter int COUNT_BITS = dccb_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dccb_pkg::t_cmd                  i_cmd,
    input  logic                            i_cmd_valid,
    output logic                            o_pop,
    input  logic [dccb_pkg::COLS_W-1:0]     i_colors,
    input  logic [dccb_pkg::RGB_W-1:0]      i_black,
    input  logic [dccb_pkg::SCALE_W-1:0]    i_scale,
    dccb_out_if.source                      o_out
);

    localparam int IW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int CB = COUNT_BITS;
    localparam int PW = COUNT_BITS + 8;    // product magnitude width
    localparam int RW = COUNT_BITS + 17;   // running sum, signed
    localparam int KW = $clog2(PW + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RANGE, S_FZ, S_MUL, S_DIV, S_ACC, S_OUT
    } t_state;

    t_state                  r_state;
    logic [23:0]             r_pal   [MAX_COLORS];
    logic [CB-1:0]           r_steps [MAX_COLORS];
    logic [CB-1:0]           r_max   [MAX_COLORS];
    logic [IW-1:0]           r_i;
    logic [1:0]              r_ch;
    logic [7:0]              r_lo  [3];
    logic [7:0]              r_hi  [3];
    logic [7:0]              r_fz  [3];
    logic signed [RW-1:0]    r_res [3];
    logic [PW-1:0]           r_num;
    logic [CB-1:0]           r_rem;
    logic                    r_neg;
    logic [KW-1:0]           r_cnt;
    logic                    r_out_valid;
    logic [7:0]              r_red, r_green, r_blue;

    logic [31:0]             w_ncol, w_nlast32;
    logic [IW-1:0]           w_nlast, w_addr, w_max_addr;
    logic [CB-1:0]           w_max_rd, w_steps_rd;
    logic [23:0]             w_pal_rd;
    logic [7:0]              w_fz [3];
    logic [8:0]              w_sc;
    logic [7:0]              w_c;
    logic signed [8:0]       w_diff;
    logic [7:0]              w_mag;
    logic [PW-1:0]           w_prod;
    logic [CB:0]             w_rem_sh;
    logic                    w_ge;
    logic signed [RW-1:0]    w_q, w_sum;
    logic [7:0]              w_outc [3];

    assign o_pop       = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.red   = r_red;
    assign o_out.green = r_green;
    assign o_out.blue  = r_blue;

    // colors taking part: zero counts as one, capped at the palette size
    assign w_ncol    = (i_colors == '0) ? 32'd1 : 32'(i_colors);
    assign w_nlast32 = (w_ncol > 32'(MAX_COLORS)) ? 32'(MAX_COLORS - 1) : w_ncol - 32'd1;
    assign w_nlast   = w_nlast32[IW-1:0];

    assign w_addr     = i_cmd.addr[IW-1:0];
    assign w_max_addr = (r_state == S_IDLE) ? w_addr : r_i;
    assign w_max_rd   = r_max[w_max_addr];
    assign w_steps_rd = r_steps[r_i];
    assign w_pal_rd   = r_pal[r_i];

    // fake zero per channel: black + trunc((max - black) * (256 - scale) / 256)
    assign w_sc = (i_scale > 9'd256) ? 9'd0 : 9'(9'd256 - i_scale);
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic signed [9:0]  d;
            logic signed [20:0] p;
            logic signed [20:0] q;
            logic [7:0]         blk;
            blk = dccb_pkg::chan_of(i_black, 2'(c));
            d = $signed({2'b00, r_hi[c]}) - $signed({2'b00, blk});
            p = 21'(d) * $signed({12'd0, w_sc});
            q = (p < 0) ? ((p + 21'sd255) >>> 8) : (p >>> 8);
            w_fz[c] = 8'(10'(blk) + q[9:0]);
        end
    end

    assign w_c    = dccb_pkg::chan_of(w_pal_rd, r_ch);
    assign w_diff = $signed({1'b0, w_c}) - $signed({1'b0, r_fz[r_ch]});
    assign w_mag  = (w_diff < 0) ? 8'(-w_diff) : w_diff[7:0];
    assign w_prod = PW'(w_max_rd) * PW'(w_mag);

    assign w_rem_sh = {r_rem, r_num[PW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, w_steps_rd});

    assign w_q   = r_neg ? -$signed(RW'(r_num)) : $signed(RW'(r_num));
    assign w_sum = r_res[r_ch] + w_q;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_outc[c] = (r_res[c] > $signed(RW'(r_hi[c]))) ? r_hi[c] : r_res[c][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_COLORS; k++) r_max[k] <= '0;
        end else begin
            // the output state reloads the result register itself
            if (o_out.ready && (r_state != S_OUT)) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.op == dccb_pkg::OP_LOAD) begin
                            if (i_cmd.hit) begin
                                r_pal[w_addr]   <= i_cmd.color;
                                r_steps[w_addr] <= i_cmd.amt[CB-1:0];
                            end
                        end else begin
                            if (i_cmd.hit && (i_cmd.amt[CB-1:0] > w_max_rd)) begin
                                r_max[w_addr] <= i_cmd.amt[CB-1:0];
                            end
                            if (i_cmd.last) begin
                                r_i <= '0;
                                for (int c = 0; c < 3; c++) begin
                                    r_lo[c] <= 8'hFF;
                                    r_hi[c] <= 8'h00;
                                end
                                r_state <= S_RANGE;
                            end
                        end
                    end
                end
                S_RANGE: begin
                    for (int c = 0; c < 3; c++) begin
                        if (dccb_pkg::chan_of(w_pal_rd, 2'(c)) < r_lo[c])
                            r_lo[c] <= dccb_pkg::chan_of(w_pal_rd, 2'(c));
                        if (dccb_pkg::chan_of(w_pal_rd, 2'(c)) > r_hi[c])
                            r_hi[c] <= dccb_pkg::chan_of(w_pal_rd, 2'(c));
                    end
                    if (r_i == w_nlast) begin
                        r_state <= S_FZ;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_FZ: begin
                    for (int c = 0; c < 3; c++) begin
                        r_fz[c]  <= w_fz[c];
                        r_res[c] <= $signed(RW'(w_fz[c]));
                    end
                    r_i     <= '0;
                    r_ch    <= 2'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_neg <= (w_diff < 0);
                    r_rem <= '0;
                    r_cnt <= KW'(PW - 1);
                    if ((w_steps_rd == '0) || (w_prod == '0)) begin
                        r_num   <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_num   <= w_prod;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? CB'(w_rem_sh - {1'b0, w_steps_rd}) : w_rem_sh[CB-1:0];
                    r_num <= {r_num[PW-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_ACC;
                end
                S_ACC: begin
                    r_res[r_ch] <= (w_sum < $signed(RW'(r_lo[r_ch]))) ?
                                   $signed(RW'(r_lo[r_ch])) : w_sum;
                    if (r_ch == 2'd2) begin
                        r_ch <= 2'd0;
                        if (r_i == w_nlast) begin
                            r_state <= S_OUT;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_red       <= w_outc[0];
                        r_green     <= w_outc[1];
                        r_blue      <= w_outc[2];
                        for (int k = 0; k < MAX_COLORS; k++) r_max[k] <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/dot_count_color_blend_core.sv =====
`timescale 1ns / 1ps
// channel  | dir | transfer when        | payload
// i_in     | in  | valid && ready       | op, color_index, color_value, amount, last_of_position
// o_out    | out | valid && ready       | red, green, blue
// i_cfg    | in  | valid (ready high)   | index, data
//
// load items and plain count items are taken in the idle state of the back end
// a position end walks the palette once for min/max, then for each color in
// use and each channel does one multiply and a restoring divide of
// COUNT_BITS+8 quotient bits, skipped when the product or the step count is zero
// the divider is shared by all colors and channels
// a four-entry queue parts the front from the back, the result register
// holds a blend while the next items queue up
// reset is synchronous, active low; config registers reset to 16 / 0 / 0
module dot_count_color_blend_core #(
    parameter int MAX_COLORS = dccb_pkg::MAX_COLORS_DEF,
    parameter int COUNT_BITS = dccb_pkg::COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dccb_in_if.sink    i_in,
    dccb_out_if.source o_out,
    dccb_cfg_if.sink   i_cfg
);

    // configuration registers
    logic [dccb_pkg::COLS_W-1:0]  r_colors;
    logic [dccb_pkg::RGB_W-1:0]   r_black;
    logic [dccb_pkg::SCALE_W-1:0] r_scale;

    // front to queue to back
    logic                 w_push;
    logic                 w_pop;
    dccb_pkg::t_cmd       w_front_cmd;
    dccb_pkg::t_cmd       w_back_cmd;
    dccb_pkg::t_fifo_stat w_stat;

    // config writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colors <= 5'd16;
            r_black  <= '0;
            r_scale  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dccb_pkg::REG_COLORS: r_colors <= i_cfg.data[dccb_pkg::COLS_W-1:0];
                dccb_pkg::REG_BLACK:  r_black  <= i_cfg.data;
                dccb_pkg::REG_SCALE:  r_scale  <= i_cfg.data[dccb_pkg::SCALE_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // front: classifies items and saturates counts
    dccb_front #(
        .MAX_COLORS(MAX_COLORS),
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_in   (i_in),
        .i_stat (w_stat),
        .o_push (w_push),
        .o_cmd  (w_front_cmd)
    );

    // short queue so front and back stall independently
    dccb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_back_cmd),
        .o_stat  (w_stat)
    );

    // back: stores, per-position maxima and the blend sequencer
    dccb_back #(
        .MAX_COLORS(MAX_COLORS),
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_back_cmd),
        .i_cmd_valid (!w_stat.empty),
        .o_pop       (w_pop),
        .i_colors    (r_colors),
        .i_black     (r_black),
        .i_scale     (r_scale),
        .o_out       (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("queue read while empty");

    a_stat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.full && w_stat.empty))
        else $error("queue full and empty at once");

endmodule
